FILE: rtl/core/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

   localparam int FRAC      = 24;
   localparam int DIV_STEPS = 48;   // quotient bits: |code| <= 2^23, shifted by FRAC
   localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      REG_CAL_LOW   = 3'd0,
      REG_CAL_MID   = 3'd1,
      REG_CAL_HIGH  = 3'd2,
      REG_MODEL     = 3'd3,
      REG_P_SCALE   = 3'd4,
      REG_T_SCALE   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [23:0] pressure_code;
      logic [23:0] temperature_code;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pressure_out;
      logic signed [23:0] temperature_out;
      logic               model_tag;
   } rsp_type;

   // values carried alongside the multipliers
   typedef struct packed {
      logic signed [63:0] ps;
      logic signed [63:0] ts;
      logic signed [63:0] tp;
      logic signed [63:0] pt;
      logic signed [63:0] t;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] q;
   } side_type;

   // saturating add of two in-range values
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      logic signed [64:0] s;
      s = 65'(x) + 65'(y);
      if (s > 65'(SAT_LIM)) return SAT_LIM;
      if (s < -65'(SAT_LIM)) return -SAT_LIM;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] coefq(input logic signed [19:0] c);
      logic signed [63:0] w;
      w = 64'(c);
      return w <<< FRAC;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/baro_pressure_temp_compensation_core.sv
`default_nettype none
// Barometric pressure and temperature compensation core.
// Input channel req_*: one word holds a raw 24-bit pressure code and a raw
// 24-bit temperature code, both two's complement.
// Result channel rsp_*: compensated pressure in 1/64 Pa (32 bit signed),
// temperature in 1/256 degC (24 bit signed), both saturated, and the model
// tag in force for that word.
// Configuration csr_*: write-only registers (calibration bytes, model select,
// the two oversampling scales); write them only while the core is empty.
// Pipeline: two 48-step restoring dividers (one quotient bit per stage), the
// four dependent multiply-add rounds (4-stage multiplier plus one add stage
// each), two accumulate stages and the rounding output register.
// Throughput: one word per cycle for as long as the receiver takes results.
// A stall on rsp_ready holds every stage and drops req_ready together; no
// word is lost or repeated.
// Reset: clears every valid bit; registers return to zero calibration, cubic
// model and scales of 7864320.
module baro_pressure_temp_compensation_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bpc_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bpc_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [63:0]       csr_wdata
);
   logic [63:0]  cal_low_ff, cal_mid_ff;
   logic [39:0]  cal_high_ff;
   logic         model_ff;
   logic [22:0]  p_scale_ff, t_scale_ff;
   logic [167:0] cal;
   logic         en;

   logic signed [19:0] c0, c1, c00, c10, c01, c11, c20, c21, c30, c31, c40;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff  <= '0;
         cal_mid_ff  <= '0;
         cal_high_ff <= '0;
         model_ff    <= 1'b0;
         p_scale_ff  <= 23'd7864320;
         t_scale_ff  <= 23'd7864320;
      end else if (csr_we) begin
         case (csr_index)
            bpc_pkg::REG_CAL_LOW:  cal_low_ff  <= csr_wdata;
            bpc_pkg::REG_CAL_MID:  cal_mid_ff  <= csr_wdata;
            bpc_pkg::REG_CAL_HIGH: cal_high_ff <= csr_wdata[39:0];
            bpc_pkg::REG_MODEL:    model_ff    <= csr_wdata[0];
            bpc_pkg::REG_P_SCALE:  p_scale_ff  <= csr_wdata[22:0];
            bpc_pkg::REG_T_SCALE:  t_scale_ff  <= csr_wdata[22:0];
            default: ;
         endcase
      end
   end

   // unpack coefficients; byte 0 sits at the top of the calibration string
   assign cal = {cal_low_ff, cal_mid_ff, cal_high_ff};
   assign c0  = 20'($signed(cal[167:156]));
   assign c1  = 20'($signed(cal[155:144]));
   assign c00 = $signed(cal[143:124]);
   assign c10 = $signed(cal[123:104]);
   assign c01 = 20'($signed(cal[103:88]));
   assign c11 = 20'($signed(cal[87:72]));
   assign c20 = 20'($signed(cal[71:56]));
   assign c21 = 20'($signed(cal[55:40]));
   assign c30 = 20'($signed(cal[39:24]));
   assign c31 = 20'($signed(cal[23:12]));
   assign c40 = 20'($signed(cal[11:0]));

   // one global advance: the whole pipe moves unless the output word is held
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // scaling dividers
   logic               pdiv_v, tdiv_v;
   logic signed [63:0] ps, ts;

   bpc_div u_pdiv (.clock, .reset, .en, .in_valid(req_valid && req_ready),
                   .code(req_data.pressure_code), .scale(p_scale_ff),
                   .out_valid(pdiv_v), .quot(ps));
   bpc_div u_tdiv (.clock, .reset, .en, .in_valid(req_valid && req_ready),
                   .code(req_data.temperature_code), .scale(t_scale_ff),
                   .out_valid(tdiv_v), .quot(ts));

   bpc_pkg::side_type  side0;
   always_comb begin
      side0    = '0;
      side0.ps = ps;
      side0.ts = ts;
   end

   // round 0: top terms, temperature products, and T
   logic               r0_v;
   logic signed [63:0] m00, m01, m02, m03, m04;
   bpc_pkg::side_type  r0_side;

   bpc_mulq u_m00 (.clock, .reset, .en, .in_valid(pdiv_v && tdiv_v),
                   .a(ps), .b(bpc_pkg::coefq(c40)), .side_in(side0),
                   .out_valid(r0_v), .p(m00), .side_out(r0_side));
   bpc_mulq u_m01 (.clock, .reset, .en, .in_valid(1'b0), .a(ps),
                   .b(bpc_pkg::coefq(c31)), .side_in(side0),
                   .out_valid(), .p(m01), .side_out());
   bpc_mulq u_m02 (.clock, .reset, .en, .in_valid(1'b0), .a(ts), .b(ps),
                   .side_in(side0), .out_valid(), .p(m02), .side_out());
   bpc_mulq u_m03 (.clock, .reset, .en, .in_valid(1'b0), .a(ts),
                   .b(bpc_pkg::coefq(c01)), .side_in(side0),
                   .out_valid(), .p(m03), .side_out());
   bpc_mulq u_m04 (.clock, .reset, .en, .in_valid(1'b0),
                   .a(bpc_pkg::coefq(c1)), .b(ts), .side_in(side0),
                   .out_valid(), .p(m04), .side_out());

   logic              s0_v_ff;
   bpc_pkg::side_type s0_ff, s0_in;
   always_comb begin
      s0_in    = r0_side;
      s0_in.a  = model_ff ? bpc_pkg::sat_add(bpc_pkg::coefq(c30), m00)
                          : bpc_pkg::coefq(c30);
      s0_in.b  = model_ff ? bpc_pkg::sat_add(bpc_pkg::coefq(c21), m01)
                          : bpc_pkg::coefq(c21);
      s0_in.tp = m02;
      s0_in.pt = m03;
      s0_in.t  = bpc_pkg::sat_add(64'(c0) <<< (bpc_pkg::FRAC - 1), m04);
   end

   // round 1: A = c20 + Psc*A, B = c11 + Psc*B
   logic               r1_v;
   logic signed [63:0] m10, m11;
   bpc_pkg::side_type  r1_side;

   bpc_mulq u_m10 (.clock, .reset, .en, .in_valid(s0_v_ff), .a(s0_ff.ps), .b(s0_ff.a),
                   .side_in(s0_ff), .out_valid(r1_v), .p(m10), .side_out(r1_side));
   bpc_mulq u_m11 (.clock, .reset, .en, .in_valid(1'b0), .a(s0_ff.ps), .b(s0_ff.b),
                   .side_in(s0_ff), .out_valid(), .p(m11), .side_out());

   logic              s1_v_ff;
   bpc_pkg::side_type s1_ff, s1_in;
   always_comb begin
      s1_in   = r1_side;
      s1_in.a = bpc_pkg::sat_add(bpc_pkg::coefq(c20), m10);
      s1_in.b = bpc_pkg::sat_add(bpc_pkg::coefq(c11), m11);
   end

   // round 2: A = c10 + Psc*A, cross term (Tsc*Psc)*B
   logic               r2_v;
   logic signed [63:0] m20, m21;
   bpc_pkg::side_type  r2_side;

   bpc_mulq u_m20 (.clock, .reset, .en, .in_valid(s1_v_ff), .a(s1_ff.ps), .b(s1_ff.a),
                   .side_in(s1_ff), .out_valid(r2_v), .p(m20), .side_out(r2_side));
   bpc_mulq u_m21 (.clock, .reset, .en, .in_valid(1'b0), .a(s1_ff.tp), .b(s1_ff.b),
                   .side_in(s1_ff), .out_valid(), .p(m21), .side_out());

   logic              s2_v_ff;
   bpc_pkg::side_type s2_ff, s2_in;
   always_comb begin
      s2_in   = r2_side;
      s2_in.a = bpc_pkg::sat_add(bpc_pkg::coefq(c10), m20);
      s2_in.q = m21;
   end

   // round 3: P = c00 + Psc*A
   logic               r3_v;
   logic signed [63:0] m30;
   bpc_pkg::side_type  r3_side;

   bpc_mulq u_m30 (.clock, .reset, .en, .in_valid(s2_v_ff), .a(s2_ff.ps), .b(s2_ff.a),
                   .side_in(s2_ff), .out_valid(r3_v), .p(m30), .side_out(r3_side));

   logic              s3_v_ff, s4_v_ff, s5_v_ff;
   bpc_pkg::side_type s3_ff, s3_in, s4_ff, s4_in, s5_ff, s5_in;
   always_comb begin
      s3_in   = r3_side;
      s3_in.a = bpc_pkg::sat_add(bpc_pkg::coefq(c00), m30);
      // accumulate in the stated order: temperature term, then cross term
      s4_in   = s3_ff;
      s4_in.a = bpc_pkg::sat_add(s3_ff.a, s3_ff.pt);
      s5_in   = s4_ff;
      s5_in.a = bpc_pkg::sat_add(s4_ff.a, s4_ff.q);
   end

   // round to nearest with ties upward, then clip to the output widths
   logic signed [63:0] p_rnd, t_rnd;
   bpc_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_v_ff;
   always_comb begin
      p_rnd = (s5_ff.a + 64'sd131072) >>> 18;
      t_rnd = (s5_ff.t + 64'sd32768) >>> 16;
      if (p_rnd > 64'sd2147483647)       rsp_in.pressure_out = 32'sh7FFF_FFFF;
      else if (p_rnd < -64'sd2147483648) rsp_in.pressure_out = 32'sh8000_0000;
      else                               rsp_in.pressure_out = p_rnd[31:0];
      if (t_rnd > 64'sd8388607)          rsp_in.temperature_out = 24'sh7F_FFFF;
      else if (t_rnd < -64'sd8388608)    rsp_in.temperature_out = 24'sh80_0000;
      else                               rsp_in.temperature_out = t_rnd[23:0];
      rsp_in.model_tag = model_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff  <= r0_v;
         s1_v_ff  <= r1_v;
         s2_v_ff  <= r2_v;
         s3_v_ff  <= r3_v;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         rsp_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff  <= s0_in;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bpc_div.sv
`default_nettype none
module bpc_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [23:0]        code,
   input  wire logic [22:0]        scale,
   output logic                    out_valid,
   output logic signed [63:0]      quot
);
   localparam int N = bpc_pkg::DIV_STEPS;

   logic              valid_ff [N+1];
   logic              neg_ff   [N+1];
   logic [N-1:0]      num_ff   [N+1];
   logic [N-1:0]      quo_ff   [N+1];
   logic [22:0]       rem_ff   [N+1];
   logic [22:0]       div_s;
   logic [23:0]       mag_in;

   // a zero divisor counts as one
   assign div_s  = (scale == 23'd0) ? 23'd1 : scale;
   assign mag_in = code[23] ? (24'd0 - code) : code;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < N; k++) valid_ff[k+1] <= valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= code[23];
         num_ff[0] <= {mag_in, (N-24)'(0)};
         quo_ff[0] <= '0;
         rem_ff[0] <= '0;
         for (int k = 0; k < N; k++) begin
            logic [23:0] sh;
            sh = {rem_ff[k], num_ff[k][N-1]};
            neg_ff[k+1] <= neg_ff[k];
            num_ff[k+1] <= num_ff[k] << 1;
            if (sh >= {1'b0, div_s}) begin
               rem_ff[k+1] <= 23'(sh - {1'b0, div_s});
               quo_ff[k+1] <= {quo_ff[k][N-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= sh[22:0];
               quo_ff[k+1] <= {quo_ff[k][N-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign quot = neg_ff[N] ? -$signed(64'(quo_ff[N])) : $signed(64'(quo_ff[N]));
endmodule
`default_nettype wire

FILE: rtl/core/bpc_mulq.sv
`default_nettype none
module bpc_mulq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic signed [63:0]    a,
   input  wire logic signed [63:0]    b,
   input  wire bpc_pkg::side_type     side_in,
   output logic                       out_valid,
   output logic signed [63:0]         p,
   output bpc_pkg::side_type          side_out
);
   logic [3:0]            valid_ff;
   bpc_pkg::side_type     side_ff [4];
   logic [2:0]            neg_ff;
   logic [62:0]           ua_ff, ub_ff;
   logic [63:0]           p0_ff, p1_ff, p2_ff, p3_ff;
   logic [127:0]          full_ff;
   logic signed [63:0]    res_ff;
   logic [61:0]           mag;
   logic signed [63:0]    res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // operands are already within the saturation range
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < 4; k++) side_ff[k] <= side_ff[k-1];
         neg_ff <= {neg_ff[1:0], a[63] ^ b[63]};
         ua_ff  <= a[63] ? 63'(-a) : a[62:0];
         ub_ff  <= b[63] ? 63'(-b) : b[62:0];
         p0_ff  <= 64'(ua_ff[31:0]) * 64'(ub_ff[31:0]);
         p1_ff  <= 64'(ua_ff[31:0]) * 64'(ub_ff[62:32]);
         p2_ff  <= 64'(ua_ff[62:32]) * 64'(ub_ff[31:0]);
         p3_ff  <= 64'(ua_ff[62:32]) * 64'(ub_ff[62:32]);
         full_ff <= {64'd0, p0_ff} + {32'd0, p1_ff, 32'd0} + {32'd0, p2_ff, 32'd0}
                    + {p3_ff, 64'd0};
         res_ff <= res_in;
      end
   end

   always_comb begin
      // shift by the fraction width; anything past bit 85 saturates
      mag = (|full_ff[127:86]) ? 62'h3FFF_FFFF_FFFF_FFFF : full_ff[85:24];
      res_in = neg_ff[2] ? -$signed(64'(mag)) : $signed(64'(mag));
   end

   assign out_valid = valid_ff[3];
   assign p         = res_ff;
   assign side_out  = side_ff[3];
endmodule
`default_nettype wire

FILE: rtl/core/bpc_checker.sv
`default_nettype none
module bpc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire bpc_pkg::req_type  req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bpc_pkg::rsp_type  rsp_data,
   input wire logic              csr_we,
   input wire logic [2:0]        csr_index,
   input wire logic [63:0]       csr_wdata
);
   // nothing comes out straight after reset
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid) else $error("result word right after reset");

   // an empty or draining output stage always lets a word in
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready) else $error("input held without cause");

   // a held output stalls the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("input taken while stalled");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result word changed under stall");
endmodule

bind baro_pressure_temp_compensation_core bpc_checker u_bpc_checker (.*);
`default_nettype wire

FILE: sim/tb_baro_pressure_temp_compensation_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_baro_pressure_temp_compensation_core;

   localparam longint LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam int RAND_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 200;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bpc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bpc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // mirror of the calibration and mode registers
   logic [63:0] cal_low, cal_mid;
   logic [39:0] cal_high;
   logic model_q;
   logic [22:0] pscale_q, tscale_q;

   bpc_pkg::rsp_type pending_rsp[$];
   int mismatches = 0;
   int words_sent = 0;
   int words_seen = 0;
   longint cycles = 0;
   bit rx_stall_en = 1'b1;

   baro_pressure_temp_compensation_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // generous watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------- compensation arithmetic ----------------
   function automatic longint clampq(input longint v);
      if (v > LIMIT) return LIMIT;
      if (v < -LIMIT) return -LIMIT;
      return v;
   endfunction

   function automatic longint qadd(input longint x, input longint y);
      return clampq(clampq(x) + clampq(y));
   endfunction

   // (x*y) >> 24 with truncation toward zero, then saturate
   function automatic longint qmul(input longint x, input longint y);
      logic [127:0] prod;
      logic [127:0] mag;
      longint ax, ay;
      bit neg;
      ax = clampq(x);
      ay = clampq(y);
      neg = (ax < 0) != (ay < 0);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      prod = 128'(ax) * 128'(ay);
      mag = prod >> bpc_pkg::FRAC;
      if (mag > 128'(LIMIT)) mag = 128'(LIMIT);
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic longint code_to_q(input logic [23:0] code, input logic [22:0] scale);
      longint r;
      longint unsigned s, quo;
      r = longint'(signed'(code));
      s = (scale == 23'd0) ? 64'd1 : 64'(scale);
      quo = (longint'(r < 0 ? -r : r) << bpc_pkg::FRAC) / s;
      return r < 0 ? -longint'(quo) : longint'(quo);
   endfunction

   function automatic longint round_out(input longint v, input int sh,
                                        input longint lo, input longint hi);
      longint x, r;
      x = v + (longint'(1) << (sh - 1));
      r = x >>> sh;  // arithmetic shift floors, matching ties toward plus infinity
      if (r > hi) return hi;
      if (r < lo) return lo;
      return r;
   endfunction

   function automatic longint cq(input longint c);
      return c * (longint'(1) << bpc_pkg::FRAC);
   endfunction

   function automatic bpc_pkg::rsp_type compensate(input bpc_pkg::req_type w);
      logic [7:0] b[21];
      longint c0, c1, c00, c10, c01, c11, c20, c21, c30, c31, c40;
      longint ps, ts, a, bb, p, t;
      bpc_pkg::rsp_type r;
      for (int i = 0; i < 8; i++) b[i] = cal_low[63 - 8*i -: 8];
      for (int i = 0; i < 8; i++) b[8+i] = cal_mid[63 - 8*i -: 8];
      for (int i = 0; i < 5; i++) b[16+i] = cal_high[39 - 8*i -: 8];
      c0  = longint'(signed'({b[0], b[1][7:4]}));
      c1  = longint'(signed'({b[1][3:0], b[2]}));
      c00 = longint'(signed'({b[3], b[4], b[5][7:4]}));
      c10 = longint'(signed'({b[5][3:0], b[6], b[7]}));
      c01 = longint'(signed'({b[8], b[9]}));
      c11 = longint'(signed'({b[10], b[11]}));
      c20 = longint'(signed'({b[12], b[13]}));
      c21 = longint'(signed'({b[14], b[15]}));
      c30 = longint'(signed'({b[16], b[17]}));
      c31 = longint'(signed'({b[18], b[19][7:4]}));
      c40 = longint'(signed'({b[19][3:0], b[20]}));
      ps = code_to_q(w.pressure_code, pscale_q);
      ts = code_to_q(w.temperature_code, tscale_q);
      a = cq(c30);
      if (model_q) a = qadd(a, qmul(ps, cq(c40)));
      a = qadd(cq(c20), qmul(ps, a));
      a = qadd(cq(c10), qmul(ps, a));
      bb = cq(c21);
      if (model_q) bb = qadd(bb, qmul(ps, cq(c31)));
      bb = qadd(cq(c11), qmul(ps, bb));
      p = qadd(cq(c00), qmul(ps, a));
      p = qadd(p, qmul(ts, cq(c01)));
      p = qadd(p, qmul(qmul(ts, ps), bb));
      t = qadd(c0 * (longint'(1) << (bpc_pkg::FRAC - 1)), qmul(cq(c1), ts));
      r.pressure_out = 32'(round_out(p, 18, -64'sd2147483648, 64'sd2147483647));
      r.temperature_out = 24'(round_out(t, 16, -64'sd8388608, 64'sd8388607));
      r.model_tag = model_q;
      return r;
   endfunction

   // ---------------- driving helpers ----------------
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 60) return 0;
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(input bpc_pkg::csr_reg_type idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         bpc_pkg::REG_CAL_LOW:  cal_low = val;
         bpc_pkg::REG_CAL_MID:  cal_mid = val;
         bpc_pkg::REG_CAL_HIGH: cal_high = val[39:0];
         bpc_pkg::REG_MODEL:    model_q = val[0];
         bpc_pkg::REG_P_SCALE:  pscale_q = val[22:0];
         bpc_pkg::REG_T_SCALE:  tscale_q = val[22:0];
         default: ;
      endcase
   endtask

   // drop valid, then wait for the pipeline to empty before touching any register
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // send one word; the expectation is either typed or predicted
   task automatic send_word(input bpc_pkg::req_type w, input bit typed,
                            input bpc_pkg::rsp_type want);
      int gap;
      gap = pick_gap();
      // lower valid only when the next word does not follow at once
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_rsp.push_back(typed ? want : compensate(w));
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // ---------------- result checking ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            bpc_pkg::rsp_type w;
            w = pending_rsp.pop_front();
            if (w.pressure_out !== rsp_data.pressure_out
                || w.temperature_out !== rsp_data.temperature_out
                || w.model_tag !== rsp_data.model_tag) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: want p=%0d t=%0d m=%0b got p=%0d t=%0d m=%0b",
                           words_seen, w.pressure_out, w.temperature_out, w.model_tag,
                           rsp_data.pressure_out, rsp_data.temperature_out,
                           rsp_data.model_tag);
            end
         end
      end
   end

   // receiver stalls: runs of ready and of not-ready
   initial begin
      int n;
      forever begin
         n = pick_gap();
         if (rx_stall_en && n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // ---------------- directed table ----------------
   typedef struct {
      logic [23:0] pc;
      logic [23:0] tc;
      bit typed;
      logic signed [31:0] p_want;
      logic signed [23:0] t_want;
   } dir_row;

   dir_row rows[$];

   task automatic random_cal();
      write_reg(bpc_pkg::REG_CAL_LOW, {$urandom, $urandom});
      write_reg(bpc_pkg::REG_CAL_MID, {$urandom, $urandom});
      write_reg(bpc_pkg::REG_CAL_HIGH, {$urandom, $urandom});
   endtask

   task automatic random_scales();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) write_reg(bpc_pkg::REG_P_SCALE, 64'd0);
      else if (k == 1) write_reg(bpc_pkg::REG_P_SCALE, 64'd1);
      else if (k == 2) write_reg(bpc_pkg::REG_P_SCALE, 64'h7F_FFFF);
      else if (k < 5) write_reg(bpc_pkg::REG_P_SCALE, 64'($urandom));
      else write_reg(bpc_pkg::REG_P_SCALE, 64'($urandom_range(253952, 7864320)));
      k = $urandom_range(0, 9);
      if (k == 0) write_reg(bpc_pkg::REG_T_SCALE, 64'd0);
      else if (k == 1) write_reg(bpc_pkg::REG_T_SCALE, 64'd1);
      else if (k == 2) write_reg(bpc_pkg::REG_T_SCALE, 64'h7F_FFFF);
      else if (k < 5) write_reg(bpc_pkg::REG_T_SCALE, 64'($urandom));
      else write_reg(bpc_pkg::REG_T_SCALE, 64'($urandom_range(253952, 7864320)));
   endtask

   initial begin
      bpc_pkg::req_type w;
      bpc_pkg::rsp_type want;
      int phase_len;
      cal_low = '0; cal_mid = '0; cal_high = '0; model_q = 1'b0;
      pscale_q = 23'd7864320; tscale_q = 23'd7864320;
      rx_stall_en = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero calibration after reset: everything reads zero
      rows.push_back('{24'h000000, 24'h000000, 1'b1, 0, 0});
      rows.push_back('{24'h7FFFFF, 24'h800000, 1'b1, 0, 0});
      rows.push_back('{24'hFFFFFF, 24'h7FFFFF, 1'b1, 0, 0});
      foreach (rows[i]) begin
         w.pressure_code = rows[i].pc;
         w.temperature_code = rows[i].tc;
         want.pressure_out = rows[i].p_want;
         want.temperature_out = rows[i].t_want;
         want.model_tag = 1'b0;
         send_word(w, rows[i].typed, want);
      end
      drain();

      // all ones calibration, both models, scale extremes: predicted rows
      write_reg(bpc_pkg::REG_CAL_LOW, '1);
      write_reg(bpc_pkg::REG_CAL_MID, '1);
      write_reg(bpc_pkg::REG_CAL_HIGH, '1);
      rows.delete();
      rows.push_back('{24'h000000, 24'h000000, 1'b0, 0, 0});
      rows.push_back('{24'h7FFFFF, 24'h7FFFFF, 1'b0, 0, 0});
      rows.push_back('{24'h800000, 24'h800000, 1'b0, 0, 0});
      rows.push_back('{24'h000001, 24'hFFFFFF, 1'b0, 0, 0});
      for (int m = 0; m < 2; m++) begin
         write_reg(bpc_pkg::REG_MODEL, 64'(m));
         for (int s = 0; s < 3; s++) begin
            write_reg(bpc_pkg::REG_P_SCALE,
                      s == 0 ? 64'd0 : (s == 1 ? 64'd1 : 64'h7F_FFFF));
            write_reg(bpc_pkg::REG_T_SCALE,
                      s == 2 ? 64'd0 : (s == 1 ? 64'd1 : 64'h7F_FFFF));
            foreach (rows[i]) begin
               w.pressure_code = rows[i].pc;
               w.temperature_code = rows[i].tc;
               send_word(w, 1'b0, want);
            end
            drain();
         end
      end

      // random phases: new registers per phase, back to back bursts inside
      while (words_sent < RAND_ITEMS + 30) begin
         random_cal();
         write_reg(bpc_pkg::REG_MODEL, 64'($urandom_range(0, 1)));
         random_scales();
         rx_stall_en = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(40, 120);
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               w.pressure_code = 24'($urandom);
               w.temperature_code = 24'($urandom);
            end else begin
               // realistic codes near zero, both signs
               w.pressure_code = 24'(signed'(32'($urandom_range(0, 600000)) - 300000));
               w.temperature_code = 24'(signed'(32'($urandom_range(0, 600000)) - 300000));
            end
            send_word(w, 1'b0, want);
         end
         drain();
      end
      rx_stall_en = 1'b1;

      drain();
      $display("%0d words sent, %0d results checked over random calibrations,",
               words_sent, words_seen);
      $display("both models and scale extremes; %0d mismatches", mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
